// ===== rtl/lmph_pkg.sv =====
// ----------------------------------------------------------------------------
// lmph_pkg: shared types and constants for the LED persistence hold block
// Sizes of the matrix, field widths, command and register codes, and the
// control bundle that the sequencer hands to the row unit.
// ----------------------------------------------------------------------------
package lmph_pkg;

   // Matrix dimensions and counter width.
   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLS    = 32;
   localparam int COUNT_WIDTH = 8;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLS);

   // Field widths of the channels.
   localparam int COLBITS_W   = 31;
   localparam int ROWSEL_W    = 32;
   localparam int LIT_W       = 32;
   localparam int OFF_DELAY_W = 8;
   localparam int COLS_USED_W = 5;
   localparam int ROWS_USED_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Width of one stored row of hold counters.
   localparam int ROW_COUNT_W = MAX_COLS * COUNT_WIDTH;

   // Register reset values.
   localparam logic [OFF_DELAY_W-1:0] OFF_DELAY_RESET = 8'd33;
   localparam logic [COLS_USED_W-1:0] COLS_USED_RESET = 5'd0;
   localparam logic [ROWS_USED_W-1:0] ROWS_USED_RESET = 6'd1;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_OFF_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_USED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_USED = 2'd2;

   // One row of hold counters.
   typedef logic [MAX_COLS-1:0][COUNT_WIDTH-1:0] count_row_type;

   // Per-row control handed to the row unit.
   typedef struct packed {
      logic                   tick;
      logic                   selected;
      logic [COL_W-1:0]       cols;
      logic [COUNT_WIDTH-1:0] reload;
      logic [COLBITS_W-1:0]   column_bits;
   } row_ctrl_type;

endpackage

// ===== rtl/lmph_if.sv =====
// ----------------------------------------------------------------------------
// lmph_if: channel interfaces of the LED persistence hold block
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface lmph_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [lmph_pkg::COLBITS_W-1:0] column_bits;
   logic [lmph_pkg::ROWSEL_W-1:0]  row_select;

   modport source (output valid, output command, output column_bits,
                   output row_select, input ready);
   modport sink   (input valid, input command, input column_bits,
                   input row_select, output ready);
endinterface

interface lmph_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lmph_pkg::ROW_W-1:0] row_index;
   logic [lmph_pkg::LIT_W-1:0] row_lit;
   logic                       last;

   modport source (output valid, output row_index, output row_lit,
                   output last, input ready);
   modport sink   (input valid, input row_index, input row_lit,
                   input last, output ready);
endinterface

interface lmph_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lmph_pkg::CSR_INDEX_W-1:0] index;
   logic [lmph_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lmph_ram.sv =====
// ----------------------------------------------------------------------------
// lmph_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data until the next read.
// ----------------------------------------------------------------------------
module lmph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lmph_row_unit.sv =====
// ----------------------------------------------------------------------------
// lmph_row_unit: shared update unit for one matrix row
// Builds the row's new pattern, decays and reloads its hold counters, and
// forms the lit bits, all columns of the row side by side.
// ----------------------------------------------------------------------------
module lmph_row_unit (
   input  lmph_pkg::row_ctrl_type         ctrl,
   input  logic                           write_pattern,
   input  logic [lmph_pkg::MAX_COLS-1:0]  pattern_old,
   input  lmph_pkg::count_row_type        counts_old,
   input  logic                           counts_valid,
   output logic [lmph_pkg::MAX_COLS-1:0]  pattern_new,
   output lmph_pkg::count_row_type        counts_new,
   output logic [lmph_pkg::LIT_W-1:0]     lit
);

   logic [lmph_pkg::MAX_COLS-1:0] col_mask;
   logic [lmph_pkg::MAX_COLS-1:0] on_bit;
   logic [lmph_pkg::MAX_COLS-1:0] in_use;
   logic [lmph_pkg::MAX_COLS-1:0] masked_cols;

   // Column masks: data columns below cols, always-on column at cols.
   always_comb begin
      on_bit      = lmph_pkg::MAX_COLS'(1) << ctrl.cols;
      col_mask    = on_bit - lmph_pkg::MAX_COLS'(1);
      in_use      = col_mask | on_bit;
      masked_cols = (lmph_pkg::MAX_COLS'(ctrl.column_bits) & col_mask) | on_bit;
   end

   // A write item replaces the pattern; a tick item keeps it.
   always_comb begin
      if (write_pattern) begin
         pattern_new = ctrl.selected ? masked_cols : '0;
      end else begin
         pattern_new = pattern_old;
      end
   end

   // Per-column counter lanes.
   always_comb begin
      logic [lmph_pkg::COUNT_WIDTH-1:0] cnt;
      for (int x = 0; x < lmph_pkg::MAX_COLS; x++) begin
         cnt = counts_valid ? counts_old[x] : '0;
         if (in_use[x]) begin
            if (ctrl.tick && (cnt != '0)) begin
               cnt = cnt - lmph_pkg::COUNT_WIDTH'(1);
            end
            if (pattern_new[x]) begin
               cnt = ctrl.reload;
            end
         end
         counts_new[x] = cnt;
         lit[x]        = in_use[x] && (cnt != '0);
      end
   end

endmodule

// ===== rtl/led_matrix_persistence_hold_top.sv =====
// ----------------------------------------------------------------------------
// led_matrix_persistence_hold_top: LED afterglow model for a strobed matrix
//
// An item on req_chan is either a pattern write or a decay tick. For each
// item the block walks the rows in use, top row first, and sends one item per
// row on rsp_chan carrying the row number, the lit columns and a last flag on
// the final row. An item that arrives while rows_used is zero produces no
// result and changes nothing.
// Registers are written on csr_chan, which is always ready; write them only
// while the block is idle.
// Timing: the item is accepted, then the row unit handles one row per cycle
// while the receiver keeps up, with the counter RAM read one row ahead;
// rows_used is capped at 32. No new item is taken while the rows are walked:
// req_chan is ready again once the last row is loaded into the output
// register.
// A stalled receiver holds the output register, which stops the row walk
// until the result is taken; no result is dropped.
// Reset clears the row patterns and marks every counter row as zero through
// per-row valid bits, so no clearing pass is needed; the registers return to
// off_delay 33, cols_used 0 and rows_used 1.
// ----------------------------------------------------------------------------
module led_matrix_persistence_hold_top (
   input  logic        clock,
   input  logic        reset,
   lmph_req_if.sink    req_chan,
   lmph_rsp_if.source  rsp_chan,
   lmph_csr_if.sink    csr_chan
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_PROC = 1'b1;

   // Configuration registers.
   logic [lmph_pkg::OFF_DELAY_W-1:0] off_delay_ff;
   logic [lmph_pkg::COLS_USED_W-1:0] cols_used_ff;
   logic [lmph_pkg::ROWS_USED_W-1:0] rows_used_ff;

   // Sequencer and latched item.
   logic                            state_ff, state_in;
   logic [lmph_pkg::ROW_W-1:0]      row_ff, row_in;
   logic                            command_ff;
   logic [lmph_pkg::COLBITS_W-1:0]  column_bits_ff;
   logic [lmph_pkg::ROWSEL_W-1:0]   row_select_ff;

   // Row state.
   logic [lmph_pkg::MAX_COLS-1:0]   pattern_ff [lmph_pkg::MAX_ROWS];
   logic [lmph_pkg::MAX_ROWS-1:0]   row_valid_ff;

   // Output register.
   logic                            rsp_valid_ff;
   logic [lmph_pkg::ROW_W-1:0]      rsp_row_index_ff;
   logic [lmph_pkg::LIT_W-1:0]      rsp_row_lit_ff;
   logic                            rsp_last_ff;

   logic [lmph_pkg::ROWS_USED_W-1:0] rows_eff;
   logic [lmph_pkg::ROW_W-1:0]       last_row;
   logic                             accept;
   logic                             out_free;
   logic                             step;
   logic                             rd_en;
   logic [lmph_pkg::ROW_W-1:0]       rd_addr;
   logic [lmph_pkg::ROW_COUNT_W-1:0] rd_data;
   lmph_pkg::row_ctrl_type           row_ctrl;
   logic [lmph_pkg::MAX_COLS-1:0]    pattern_new;
   lmph_pkg::count_row_type          counts_new;
   logic [lmph_pkg::LIT_W-1:0]       lit;

   // Effective row count, capped at the matrix size.
   assign rows_eff = (rows_used_ff > lmph_pkg::ROWS_USED_W'(lmph_pkg::MAX_ROWS))
                   ? lmph_pkg::ROWS_USED_W'(lmph_pkg::MAX_ROWS) : rows_used_ff;
   assign last_row = lmph_pkg::ROW_W'(rows_eff - lmph_pkg::ROWS_USED_W'(1));

   // Handshakes.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && (state_ff == S_IDLE) && (rows_eff != '0);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = (state_ff == S_PROC) && out_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_delay_ff <= lmph_pkg::OFF_DELAY_RESET;
         cols_used_ff <= lmph_pkg::COLS_USED_RESET;
         rows_used_ff <= lmph_pkg::ROWS_USED_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            lmph_pkg::REG_OFF_DELAY: off_delay_ff <= csr_chan.data;
            lmph_pkg::REG_COLS_USED: cols_used_ff <= lmph_pkg::COLS_USED_W'(csr_chan.data);
            lmph_pkg::REG_ROWS_USED: rows_used_ff <= lmph_pkg::ROWS_USED_W'(csr_chan.data);
            default: ;
         endcase
      end
   end

   // Sequencer: accept an item, then step one row per cycle while the output register is free.
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PROC;
               row_in   = '0;
            end
         end
         S_PROC: begin
            if (step) begin
               if (row_ff == last_row) begin
                  state_in = S_IDLE;
               end else begin
                  row_in = row_ff + lmph_pkg::ROW_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   // Latch the item's payload at acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff     <= req_chan.command;
         column_bits_ff <= req_chan.column_bits;
         row_select_ff  <= req_chan.row_select;
      end
   end

   // Counter RAM read runs one row ahead of the row unit.
   assign rd_en   = accept || (step && (row_ff != last_row));
   assign rd_addr = accept ? '0 : row_ff + lmph_pkg::ROW_W'(1);

   lmph_ram #(
      .WIDTH (lmph_pkg::ROW_COUNT_W),
      .DEPTH (lmph_pkg::MAX_ROWS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (row_ff),
      .wr_data (counts_new),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Row unit control for the current row.
   always_comb begin
      row_ctrl.tick        = (command_ff == lmph_pkg::CMD_TICK);
      row_ctrl.selected    = row_select_ff[row_ff];
      row_ctrl.cols        = lmph_pkg::COL_W'(cols_used_ff);
      row_ctrl.reload      = lmph_pkg::COUNT_WIDTH'(off_delay_ff);
      row_ctrl.column_bits = column_bits_ff;
   end

   lmph_row_unit u_row_unit (
      .ctrl          (row_ctrl),
      .write_pattern (command_ff == lmph_pkg::CMD_WRITE),
      .pattern_old   (pattern_ff[row_ff]),
      .counts_old    (rd_data),
      .counts_valid  (row_valid_ff[row_ff]),
      .pattern_new   (pattern_new),
      .counts_new    (counts_new),
      .lit           (lit)
   );

   // Row patterns and counter-row valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int y = 0; y < lmph_pkg::MAX_ROWS; y++) begin
            pattern_ff[y] <= '0;
         end
         row_valid_ff <= '0;
      end else if (step) begin
         pattern_ff[row_ff]   <= pattern_new;
         row_valid_ff[row_ff] <= 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_row_index_ff <= row_ff;
         rsp_row_lit_ff   <= lit;
         rsp_last_ff      <= (row_ff == last_row);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.row_index = rsp_row_index_ff;
   assign rsp_chan.row_lit   = rsp_row_lit_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule
